// ===== sv/memory_pattern_test_sequencer_top_defines.svh =====
`ifndef MEMORY_PATTERN_TEST_SEQUENCER_TOP_DEFINES_SVH
`define MEMORY_PATTERN_TEST_SEQUENCER_TOP_DEFINES_SVH

// Concurrent checks on the rising edge of clk, suspended while rst is high.

// The consequent must hold in the same cycle as the antecedent.
`define MPTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mpts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mpts_pkg;

  // Default width of the test patterns and of the read-back compare.
  localparam int MPTS_DATA_WIDTH = 32;

  // Request codes.
  localparam logic REQ_START = 1'b0;

  // Access kinds on the result channel.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_ADDRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PORT   = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [31:0] read_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  access_kind;
    logic        port_out;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] error_count;
    logic        done_res;
  } res_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic        start;
    logic [31:0] read_data;
  } cmd_t;

  // Configuration write strobe, index and data.
  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== sv/mpts_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "memory_pattern_test_sequencer_top_defines.svh"

module mpts_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  // Two entries, enough for full rate with a registered full flag.
  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  `MPTS_ASSERT_SAME(a_count_bound, 1'b1, count <= 2'd2, "fifo count beyond depth")
  `MPTS_ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + 2'd1,
                    "fifo count did not grow on a lone push")
  `MPTS_ASSERT_NEXT(a_count_down, do_pop && !do_push, count == $past(count) - 2'd1,
                    "fifo count did not shrink on a lone pop")

endmodule

`default_nettype wire

// ===== sv/mpts_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mpts_front
  import mpts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t request,
  output logic full,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  cmd_t                   cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_q;
  logic                   cmd_empty;

  // Sort each request into a restart or an advance before it is queued.
  always_comb begin
    cmd_in.start     = (request.req_type == REQ_START);
    cmd_in.read_data = request.read_data;
  end

  mpts_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd_in),
    .full (full),
    .pop  (cmd_ready),
    .dout (cmd_q),
    .empty(cmd_empty)
  );

  assign cmd       = cmd_t'(cmd_q);
  assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// ===== sv/mpts_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "memory_pattern_test_sequencer_top_defines.svh"

module mpts_back
  import mpts_pkg::*;
#(
  parameter int DATA_WIDTH = MPTS_DATA_WIDTH
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg_wr,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_ready,
  input  logic    pop,
  output logic    empty,
  output res_t    result
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_WALK = 3'd1;
  localparam logic [2:0] PH_AWR  = 3'd2;
  localparam logic [2:0] PH_ARD  = 3'd3;
  localparam logic [2:0] PH_CWR  = 3'd4;
  localparam logic [2:0] PH_CRD  = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  localparam logic [DATA_WIDTH-1:0] TOPBIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [31:0]           start_addr;
  logic [31:0]           end_addr;
  logic                  tgt_port;

  logic [2:0]            phase;
  logic [2:0]            phase_next;
  logic [31:0]           cur_addr;
  logic [31:0]           cur_addr_next;
  logic [DATA_WIDTH-1:0] walk;
  logic [DATA_WIDTH-1:0] walk_next;
  logic [1:0]            sub_step;
  logic [1:0]            sub_step_next;
  logic [DATA_WIDTH-1:0] expected;
  logic [DATA_WIDTH-1:0] expected_next;
  logic                  read_pending;
  logic                  read_pending_next;
  logic [31:0]           mcount;
  logic [31:0]           mcount_next;

  logic                  fire;
  logic                  res_full;
  logic [32:0]           addr_sum;
  logic                  range_fin;
  logic [31:0]           step_addr;
  logic                  testing;
  logic [63:0]           rd64;
  logic [DATA_WIDTH-1:0] rd_dw;
  logic [63:0]           a64;
  logic [DATA_WIDTH-1:0] a_dw;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] exp_val;
  logic [63:0]           wdata64;
  logic                  active;
  logic [1:0]            kind;
  res_t                  res_in;
  logic [$bits(res_t)-1:0] res_q;

  assign cmd_ready = !res_full;
  assign fire      = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= 32'd0;
      end_addr   <= 32'd0;
      tgt_port   <= 1'b0;
    end else if (cfg_wr.en) begin
      unique case (cfg_wr.index)
        CFG_START_ADDRESS: start_addr <= cfg_wr.data;
        CFG_END_ADDRESS:   end_addr   <= cfg_wr.data;
        CFG_TARGET_PORT:   tgt_port   <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    addr_sum  = {1'b0, cur_addr} + 33'd4;
    range_fin = addr_sum[32] || (addr_sum[31:0] >= end_addr);
    step_addr = range_fin ? start_addr : addr_sum[31:0];
    testing   = (phase >= PH_WALK) && (phase <= PH_CRD);
    rd64      = {32'd0, cmd.read_data};
    rd_dw     = rd64[DATA_WIDTH-1:0];

    phase_next    = phase;
    cur_addr_next = cur_addr;
    walk_next     = walk;
    sub_step_next = sub_step;
    mcount_next   = mcount;

    if (cmd.start) begin
      mcount_next   = 32'd0;
      cur_addr_next = start_addr;
      walk_next     = TOPBIT;
      sub_step_next = 2'd0;
      phase_next    = (start_addr < end_addr) ? PH_WALK : PH_DONE;
    end else if (testing) begin
      if (read_pending && (rd_dw != expected) && (mcount != 32'hFFFF_FFFF)) begin
        mcount_next = mcount + 32'd1;
      end
      unique case (phase)
        PH_WALK: begin
          if (sub_step != 2'd3) begin
            sub_step_next = sub_step + 2'd1;
          end else begin
            sub_step_next = 2'd0;
            if (walk[DATA_WIDTH-1:1] != '0) begin
              walk_next = walk >> 1;
            end else begin
              walk_next     = TOPBIT;
              cur_addr_next = step_addr;
              if (range_fin) begin
                phase_next = PH_AWR;
              end
            end
          end
        end
        PH_AWR, PH_ARD, PH_CWR: begin
          cur_addr_next = step_addr;
          if (range_fin) begin
            phase_next = phase + 3'd1;
          end
        end
        PH_CRD: begin
          cur_addr_next = step_addr;
          if (range_fin) begin
            phase_next = PH_DONE;
          end
        end
        default: ;
      endcase
    end

    // The access issued for this beat follows from the state just reached.
    a64     = {32'd0, cur_addr_next};
    a_dw    = a64[DATA_WIDTH-1:0];
    kind    = KIND_NONE;
    wdata   = '0;
    exp_val = '0;
    active  = 1'b1;
    unique case (phase_next)
      PH_WALK: begin
        unique case (sub_step_next)
          2'd0: begin
            kind  = KIND_WRITE;
            wdata = walk_next;
          end
          2'd1: begin
            kind    = KIND_READ;
            exp_val = walk_next;
          end
          2'd2: begin
            kind  = KIND_WRITE;
            wdata = ~walk_next;
          end
          default: begin
            kind    = KIND_READ;
            exp_val = ~walk_next;
          end
        endcase
      end
      PH_AWR: begin
        kind  = KIND_WRITE;
        wdata = a_dw;
      end
      PH_ARD: begin
        kind    = KIND_READ;
        exp_val = a_dw;
      end
      PH_CWR: begin
        kind  = KIND_WRITE;
        wdata = ~a_dw;
      end
      PH_CRD: begin
        kind    = KIND_READ;
        exp_val = ~a_dw;
      end
      default: active = 1'b0;
    endcase

    read_pending_next = active && (kind == KIND_READ);
    expected_next     = read_pending_next ? exp_val : expected;
    wdata64           = 64'(wdata);

    res_in.access_kind = kind;
    res_in.port_out    = active && tgt_port;
    res_in.address     = active ? cur_addr_next : 32'd0;
    res_in.write_data  = active ? wdata64[31:0] : 32'd0;
    res_in.error_count = mcount_next;
    res_in.done_res    = (phase_next == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      cur_addr     <= 32'd0;
      walk         <= '0;
      sub_step     <= 2'd0;
      expected     <= '0;
      read_pending <= 1'b0;
      mcount       <= 32'd0;
    end else if (fire) begin
      phase        <= phase_next;
      cur_addr     <= cur_addr_next;
      walk         <= walk_next;
      sub_step     <= sub_step_next;
      expected     <= expected_next;
      read_pending <= read_pending_next;
      mcount       <= mcount_next;
    end
  end

  mpts_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (fire),
    .din  (res_in),
    .full (res_full),
    .pop  (pop),
    .dout (res_q),
    .empty(empty)
  );

  assign result = res_t'(res_q);

  `MPTS_ASSERT_NEXT(a_start_enters_walk, fire && cmd.start && (start_addr < end_addr),
                    phase == PH_WALK, "start with a non-empty range did not enter walk")
  `MPTS_ASSERT_NEXT(a_count_monotonic, fire && !cmd.start, mcount >= $past(mcount),
                    "error count dropped without a start")
  `MPTS_ASSERT_SAME(a_walk_nonzero, phase == PH_WALK, walk != '0,
                    "walking pattern lost its set bit")
  `MPTS_ASSERT_SAME(a_done_no_read, phase == PH_DONE, !read_pending,
                    "read pending while done")

endmodule

`default_nettype wire

// ===== sv/memory_pattern_test_sequencer_top.sv =====
// Channel   Handshake         Payload            Beat moves
// request   push / full       req_t   request    start or advance plus read-back data
// result    pop / empty       res_t   result     one memory access and status
// config    wr_en             wr_index, wr_data  one register write, no wait
//
// Each accepted request yields exactly one result, in order; one request a cycle is
// sustained while results are popped, set by the update of the sequencer state in the
// back end. An accepted request waits in the request queue until the back end takes it;
// the back end then writes its result into the result queue, from which it can be
// popped. Reset is synchronous on rst and returns the test to idle. The two-entry
// queues on each side let push and pop stall independently; full rises only when
// both queues have filled because results are not being popped.
`timescale 1ns / 1ps
`default_nettype none

module memory_pattern_test_sequencer_top
  import mpts_pkg::*;
#(
  parameter int DATA_WIDTH = MPTS_DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  req_t                 request,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output res_t                 result,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]          wr_data
);

  // Classified requests flow from the front end to the sequencer through this link.
  logic    cmd_valid;
  logic    cmd_ready;
  cmd_t    cmd;
  cfg_wr_t cfg_wr;

  // Register writes are bundled for the sequencer, which owns the address range
  // and port registers.
  always_comb begin
    cfg_wr.en    = wr_en;
    cfg_wr.index = wr_index;
    cfg_wr.data  = wr_data;
  end

  // The front end queues incoming beats and tags each as a restart or an advance.
  mpts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .request  (request),
    .full     (full),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  // The back end checks the previous read, steps the pattern state and queues
  // the next access as a result beat.
  mpts_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_ready(cmd_ready),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

`default_nettype wire

// ===== sim/memory_pattern_test_sequencer_top_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the memory pattern test sequencer.
//
// The sequencer is treated as a pair of queues: request beats go in on
// push/full and access beats come out on pop/empty, one access per request.
// A behavioral model of the sweep runs beside the block. Every request that
// the block accepts is run through the model at that same clock edge. The
// access the model predicts is queued and compared with the next access the
// block hands out.
//
// The stimulus is built ahead of time by the initial block into a queue of
// pending requests. A second copy of the sweep state, the "plan", follows the
// same requests. That lets the generator answer most reads with the data an
// ideal memory would return, so the sweeps get through all five phases. A
// share of the reads get wrong data so that the error counter moves.
module memory_pattern_test_sequencer_top_tb;
  import mpts_pkg::*;

  localparam real CLK_PERIOD  = 10.0;
  localparam int  STALL_LIMIT = 2000;
  localparam int  MAX_REPORTS = 10;

  // The package only names the start code; the other request is an advance.
  localparam logic REQ_ADVANCE = 1'b1;

  localparam logic [31:0] WALK_TOP = 32'h8000_0000;

  // Where the sweep stands. The order matters: every phase hands over to the
  // next code when its address range runs out.
  typedef enum logic [2:0] {
    TP_IDLE,
    TP_WALK,
    TP_ADDR_WRITE,
    TP_ADDR_READ,
    TP_INV_WRITE,
    TP_INV_READ,
    TP_DONE
  } sweep_phase_e;

  typedef struct packed {
    sweep_phase_e phase;
    logic [1:0]   sub_step;      // walk: write, read, write inverted, read inverted
    logic [31:0]  addr;
    logic [31:0]  walk;          // the single set bit of the walking pattern
    logic [31:0]  want;          // data the last read access should return
    logic         read_pending;
    logic [31:0]  errors;
  } sweep_state_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  req_t                 request = '0;
  logic                 full;
  logic                 pop = 1'b0;
  logic                 empty;
  res_t                 result;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = CFG_START_ADDRESS;
  logic [31:0]          wr_data = '0;

  // The bench's own copy of the registers, updated as they are written.
  logic [31:0] cfg_start = '0;
  logic [31:0] cfg_end = '0;
  logic        cfg_port = 1'b0;

  // The model state follows accepted requests; the plan follows generated ones.
  sweep_state_t model = '0;
  sweep_state_t plan = '0;

  req_t pending_q[$];
  res_t access_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold = 0;
  int stall_cycles = 0;

  int n_accepted = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int n_starts = 0;
  int n_bad_reads = 0;
  int n_sweeps = 0;

  memory_pattern_test_sequencer_top dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .request  (request),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Advance the sweep by one request and describe the access it leads to.
  // A start always restarts from the start address and clears the error
  // count. An advance first checks the data of a pending read, then steps
  // the sweep. When the last address of a phase has been used, the address
  // returns to the start and the next phase begins. An address step that
  // would carry past the top of the 32-bit space also ends the phase.
  function automatic res_t predict_access(inout sweep_state_t s, input req_t r);
    res_t        acc;
    logic [32:0] nxt_addr;
    logic        step_addr;
    logic        is_read;
    logic [31:0] pattern;
    acc = '0;
    step_addr = 1'b0;
    if (r.req_type == REQ_START) begin
      s.errors = '0;
      s.addr = cfg_start;
      s.walk = WALK_TOP;
      s.sub_step = 2'd0;
      s.phase = (cfg_start < cfg_end) ? TP_WALK : TP_DONE;
    end else if (s.phase != TP_IDLE && s.phase != TP_DONE) begin
      if (s.read_pending && r.read_data != s.want && s.errors != '1) begin
        s.errors = s.errors + 32'd1;
      end
      if (s.phase == TP_WALK) begin
        if (s.sub_step != 2'd3) begin
          s.sub_step = s.sub_step + 2'd1;
        end else begin
          s.sub_step = 2'd0;
          s.walk = s.walk >> 1;
          if (s.walk == '0) begin
            s.walk = WALK_TOP;
            step_addr = 1'b1;
          end
        end
      end else begin
        step_addr = 1'b1;
      end
      if (step_addr) begin
        nxt_addr = {1'b0, s.addr} + 33'd4;
        if (nxt_addr[32] || nxt_addr[31:0] >= cfg_end) begin
          s.addr = cfg_start;
          s.phase = sweep_phase_e'(s.phase + 1);
        end else begin
          s.addr = nxt_addr[31:0];
        end
      end
    end

    s.read_pending = 1'b0;
    acc.access_kind = KIND_NONE;
    acc.error_count = s.errors;
    acc.done_res = (s.phase == TP_DONE);
    if (s.phase != TP_IDLE && s.phase != TP_DONE) begin
      acc.port_out = cfg_port;
      acc.address = s.addr;
      case (s.phase)
        TP_WALK: begin
          pattern = s.sub_step[1] ? ~s.walk : s.walk;
          is_read = s.sub_step[0];
        end
        TP_ADDR_WRITE, TP_ADDR_READ: begin
          pattern = s.addr;
          is_read = (s.phase == TP_ADDR_READ);
        end
        default: begin
          pattern = ~s.addr;
          is_read = (s.phase == TP_INV_READ);
        end
      endcase
      if (is_read) begin
        acc.access_kind = KIND_READ;
        s.read_pending = 1'b1;
        s.want = pattern;
      end else begin
        acc.access_kind = KIND_WRITE;
        acc.write_data = pattern;
      end
    end
    return acc;
  endfunction

  task automatic log_mismatch(input string what);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  // Appends one request to the pending queue and moves the plan along with it.
  task automatic queue_item(input logic kind, input logic [31:0] data);
    req_t item;
    item.req_type = kind;
    item.read_data = data;
    if (kind == REQ_START) begin
      n_starts++;
    end else if (plan.read_pending && data != plan.want) begin
      n_bad_reads++;
    end
    void'(predict_access(plan, item));
    pending_q.push_back(item);
  endtask

  // An advance whose data is mostly what an ideal memory would return after
  // a read. Otherwise one bit is flipped, or the whole word is random.
  task automatic queue_advance();
    logic [31:0] data;
    data = $urandom;
    if (plan.read_pending && $urandom_range(9) != 0) begin
      data = plan.want;
    end else if (plan.read_pending && $urandom_range(1) == 0) begin
      data = plan.want ^ (32'd1 << $urandom_range(31));
    end
    queue_item(REQ_ADVANCE, data);
  endtask

  // Registers are written back to back; the enable is lowered once at the end.
  task automatic program_regs(input logic [31:0] first, input logic [31:0] last,
                              input logic port);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= CFG_START_ADDRESS;
    wr_data <= first;
    @(posedge clk);
    wr_index <= CFG_END_ADDRESS;
    wr_data <= last;
    @(posedge clk);
    wr_index <= CFG_TARGET_PORT;
    wr_data <= {31'd0, port};
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_start = first;
    cfg_end = last;
    cfg_port = port;
  endtask

  // Holds the stimulus back until every pending request has gone in and every
  // predicted access has come out. It then waits on so that the block is surely quiet.
  task automatic wait_drain();
    do @(negedge clk); while (pending_q.size() != 0 || push || access_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // One batch of random sweeps under one register setting and one idling mode.
  // It opens with up to two advances that carry on whatever sweep the previous
  // batch left behind. The registers have just changed, so this also checks
  // that the new start takes effect only when the next phase begins. Then come
  // complete sweeps with random data, some cut short by a restart, each followed
  // by up to two advances, which land in the done state once a sweep has finished.
  task automatic run_batch(input logic [31:0] first, input logic [31:0] last,
                           input logic port, input int sender_idle,
                           input int receiver_stall, input int hold, input int budget);
    int n;
    program_regs(first, last, port);
    @(negedge clk);
    send_idle_pct = sender_idle;
    recv_stall_pct = receiver_stall;
    recv_hold = hold;
    n = 0;
    repeat ($urandom_range(2)) begin
      queue_advance();
      n++;
    end
    while (n < budget) begin
      queue_item(REQ_START, $urandom);
      n++;
      while (n < budget && plan.phase != TP_DONE && $urandom_range(999) != 0) begin
        queue_advance();
        n++;
      end
      repeat ($urandom_range(2)) begin
        if (n < budget) begin
          queue_advance();
          n++;
        end
      end
    end
    wait_drain();
  endtask

  // Driver: presents pending requests on push. When a beat is accepted, it
  // runs the request through the model and queues the predicted access.
  always @(posedge clk) begin : driver
    req_t         nxt;
    res_t         acc;
    sweep_phase_e was;
    if (rst) begin
      push <= 1'b0;
      request <= '0;
    end else begin
      if (push && !full) begin
        was = model.phase;
        acc = predict_access(model, request);
        access_q.push_back(acc);
        n_accepted++;
        if (was == TP_INV_READ && model.phase == TP_DONE) n_sweeps++;
      end
      if (!push || !full) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          request <= nxt;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes accesses off the block and compares each one with the
  // oldest prediction. While a hold-off is counting down, it keeps pop low.
  always @(posedge clk) begin : monitor
    res_t acc;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_checked++;
        if (access_q.size() == 0) begin
          log_mismatch($sformatf("access with none predicted: kind %0d addr %08h",
                                 result.access_kind, result.address));
        end else begin
          acc = access_q.pop_front();
          if (result.access_kind !== acc.access_kind || result.port_out !== acc.port_out ||
              result.address !== acc.address || result.write_data !== acc.write_data ||
              result.error_count !== acc.error_count || result.done_res !== acc.done_res) begin
            log_mismatch($sformatf({"access %0d: expected kind %0d port %0d addr %08h ",
                                    "data %08h errors %0d done %0d, got kind %0d port %0d ",
                                    "addr %08h data %08h errors %0d done %0d"},
                                   n_checked, acc.access_kind, acc.port_out, acc.address,
                                   acc.write_data, acc.error_count, acc.done_res,
                                   result.access_kind, result.port_out, result.address,
                                   result.write_data, result.error_count, result.done_res));
          end
        end
      end
      if (recv_hold != 0) begin
        recv_hold = recv_hold - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: counts the cycles in which work is outstanding but no beat
  // moves on either side.
  always @(posedge clk) begin : watchdog
    if (rst || (push && !full) || (pop && !empty) ||
        (pending_q.size() == 0 && access_q.size() == 0 && !push)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles with work outstanding", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] base;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Right after reset all registers are zero. An advance in idle must give
    // no access, and a start over the empty range must go to done at once.
    // Advances after that stay in done.
    queue_item(REQ_ADVANCE, 32'hFFFF_FFFF);
    queue_item(REQ_START, 32'h0000_0000);
    queue_item(REQ_ADVANCE, 32'h0000_0000);
    queue_item(REQ_ADVANCE, 32'h5A5A_A5A5);
    wait_drain();

    // The top word of the address space on port 1. Reads are answered correctly
    // and also with all ones and all zeros against walking patterns. A restart
    // in the middle must clear the error count.
    program_regs(32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1);
    @(negedge clk);
    queue_item(REQ_START, 32'hFFFF_FFFF);
    queue_item(REQ_ADVANCE, 32'h0000_0000);
    queue_item(REQ_ADVANCE, plan.want);
    queue_item(REQ_ADVANCE, 32'hFFFF_FFFF);
    queue_item(REQ_ADVANCE, 32'hFFFF_FFFF);
    queue_item(REQ_ADVANCE, 32'h0000_0000);
    queue_item(REQ_ADVANCE, 32'h0000_0000);
    queue_item(REQ_ADVANCE, 32'h1234_5678);
    queue_item(REQ_ADVANCE, plan.want);
    queue_item(REQ_START, 32'h0000_0000);
    queue_item(REQ_ADVANCE, 32'hFFFF_FFFF);
    queue_item(REQ_ADVANCE, 32'h0000_0000);
    wait_drain();

    // A start address above the end address is also an empty range.
    program_regs(32'h0000_0010, 32'h0000_000C, 1'b0);
    @(negedge clk);
    queue_item(REQ_START, 32'hDEAD_BEEF);
    queue_item(REQ_ADVANCE, 32'h0000_0000);
    wait_drain();

    // One word, no idling. The receiver holds off for a long stretch at the
    // start while the sender keeps offering, so both queues fill and full rises.
    run_batch(32'h0000_0100, 32'h0000_0104, 1'b1, 0, 0, 60, 130);
    // The last word before the address space wraps, with an idle sender.
    run_batch(32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0, 73, 0, 0, 130);
    // An unaligned start used as given, with a stalling receiver.
    run_batch(32'h0000_0013, 32'h0000_0016, 1'b1, 0, 73, 0, 130);
    // Two words at a random aligned base, so that every phase steps an
    // address. Both sides idle.
    base = $urandom & 32'hFFFF_FFFC;
    if (base > 32'hFFFF_FFF0) base = 32'hFFFF_FFF0;
    run_batch(base, base + 32'd8, 1'($urandom_range(1)), 23, 23, 0, 280);
    // The whole address space: only the start of the walk is reached.
    run_batch(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 0, 0, 0, 60);

    if (access_q.size() != 0) begin
      log_mismatch($sformatf("%0d predicted accesses never came out", access_q.size()));
    end
    $display("Covered %0d requests: %0d starts and %0d reads answered with bad data.",
             n_accepted, n_starts, n_bad_reads);
    $display("Checked %0d accesses, %0d sweeps ran all phases to done, %0d mismatches.",
             n_checked, n_sweeps, n_mismatch);
    if (n_mismatch == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mpts_pkg.sv
sv/mpts_fifo.sv
sv/mpts_front.sv
sv/mpts_back.sv
sv/memory_pattern_test_sequencer_top.sv
sim/memory_pattern_test_sequencer_top_tb.sv
